@@ design/knapsack_01_best_value_top_defines.svh @@
// Assertion macros for the knapsack best-value block.
`ifndef KNAPSACK_01_BEST_VALUE_TOP_DEFINES_SVH
`define KNAPSACK_01_BEST_VALUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KNAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KNAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/knap_pkg.sv @@
// Package: field widths and sequencer states for the knapsack best-value block.
`timescale 1ns / 1ps
`default_nettype none
package knap_pkg;

  localparam int CAP_W = 11;
  localparam int WGT_W = 20;
  localparam int VAL_W = 20;
  localparam int OUT_W = 40;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } knap_state_t;

endpackage
`default_nettype wire

@@ design/knap_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module knap_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/knapsack_01_best_value_top.sv @@
// Knapsack best value: clearing pass at reset (every entry zeroed, busy high), then
// one table sweep per item, one entry per cycle through two mirrored table RAMs.
// Non-last item of weight w <= MAX_CAPACITY: busy while entries MAX_CAPACITY down to w are swept and drained.
// Last item: full sweep that also zeroes the table, busy through drain and done, result
// strobed in the cycle busy drops. Heavier non-last items are absorbed with no busy time.
// Synchronous active-low reset; the result strobe cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "knapsack_01_best_value_top_defines.svh"
module knapsack_01_best_value_top
  import knap_pkg::*;
#(
  parameter int MAX_CAPACITY = 1024,
  parameter int VALUE_WIDTH  = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WGT_W-1:0] in_item_weight,
  input  wire logic [VAL_W-1:0] in_item_value,
  input  wire logic             in_last_item,
  output logic                  out_strobe,
  output logic [OUT_W-1:0]      out_best_value,
  output logic                  out_overflowed,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_capacity
);

  localparam int AW = $clog2(MAX_CAPACITY + 1);
  localparam int CW = (AW > CAP_W) ? AW : CAP_W;
  localparam int SW = ((VALUE_WIDTH > VAL_W) ? VALUE_WIDTH : VAL_W) + 1;
  localparam logic [AW-1:0]          MAX_A = AW'(MAX_CAPACITY);
  localparam logic [CW-1:0]          MAX_C = CW'(MAX_CAPACITY);
  localparam logic [WGT_W-1:0]       MAX_WGT = WGT_W'(MAX_CAPACITY);
  localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

  knap_state_t state_r, state_nxt;

  logic [CAP_W-1:0]       cap_r;
  logic [AW-1:0]          wgt_r;
  logic [VAL_W-1:0]       val_r;
  logic                   last_r;
  logic                   wok_r;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]          s1_addr_r;
  logic                   s1_take_r;
  logic                   sat_r, sat_nxt;
  logic [VALUE_WIDTH-1:0] cap_val_r, cap_val_nxt;
  logic                   out_strobe_r;
  logic [OUT_W-1:0]       out_best_r;
  logic                   out_ovf_r;

  logic                   accept;
  logic [AW-1:0]          lo_addr;
  logic                   take0;
  logic [AW-1:0]          off_addr;
  logic [AW-1:0]          cap_sel;
  logic [CW-1:0]          cap_ext;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] rd_self, rd_off;

  logic [SW-1:0]          sum;
  logic                   sum_sat;
  logic [VALUE_WIDTH-1:0] cand;
  logic [VALUE_WIDTH-1:0] new_val;
  logic [63:0]            cap_val_wide;

  assign accept   = start && !busy;
  assign lo_addr  = last_r ? '0 : wgt_r;
  assign take0    = wok_r && (addr_r >= wgt_r);
  assign off_addr = addr_r - wgt_r;
  assign cap_ext  = CW'(cap_r);
  assign cap_sel  = (cap_ext > MAX_C) ? MAX_A : AW'(cap_ext);

  // entry c and entry c-w, one copy each; both copies see the same writes
  knap_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_CAPACITY + 1)) u_ram_self (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (rd_self)
  );

  knap_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_CAPACITY + 1)) u_ram_off (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (off_addr),
    .rdata (rd_off)
  );

  // update stage; descending sweep never reads an entry already written this pass
  assign sum     = SW'(rd_off) + SW'(val_r);
  assign sum_sat = sum > SW'(VMAX);
  assign cand    = sum_sat ? VMAX : sum[VALUE_WIDTH-1:0];
  assign new_val = (s1_take_r && (cand > rd_self)) ? cand : rd_self;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == '0) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (in_last_item || (in_item_weight <= MAX_WGT))) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (addr_r == lo_addr) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy         = 1'b1;
    addr_nxt     = addr_r;
    s1_valid_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = s1_addr_r;
    ram_wdata    = last_r ? '0 : new_val;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        addr_nxt  = addr_r - 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        addr_nxt = MAX_A;
      end
      ST_SWEEP: begin
        s1_valid_nxt = 1'b1;
        addr_nxt     = addr_r - 1'b1;
        ram_we       = s1_valid_r && (s1_take_r || last_r);
      end
      ST_DRAIN: begin
        ram_we = s1_valid_r && (s1_take_r || last_r);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sat_nxt     = sat_r;
    cap_val_nxt = cap_val_r;
    if (s1_valid_r) begin
      if (s1_take_r && sum_sat) sat_nxt = 1'b1;
      if (s1_addr_r == cap_sel) cap_val_nxt = new_val;
    end
    if (state_r == ST_DONE) sat_nxt = 1'b0;
  end

  assign cap_val_wide = 64'(cap_val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= MAX_A;
      s1_valid_r   <= 1'b0;
      sat_r        <= 1'b0;
      cap_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      s1_valid_r   <= s1_valid_nxt;
      sat_r        <= sat_nxt;
      out_strobe_r <= (state_r == ST_DONE);
      if (cfg_we) cap_r <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= addr_r;
    s1_take_r <= take0;
    cap_val_r <= cap_val_nxt;
    if (accept) begin
      wgt_r  <= AW'(in_item_weight);
      val_r  <= in_item_value;
      last_r <= in_last_item;
      wok_r  <= in_item_weight <= MAX_WGT;
    end
    if (state_r == ST_DONE) begin
      out_best_r <= cap_val_wide[OUT_W-1:0];
      out_ovf_r  <= sat_r;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_best_value = out_best_r;
  assign out_overflowed = out_ovf_r;

  `KNAP_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `KNAP_ASSERT_NEXT(a_done_emits, state_r == ST_DONE, out_strobe && !sat_r, "set end lost result or flag")
  `KNAP_ASSERT_NOW(a_s1_in_sweep, s1_valid_r, state_r == ST_SWEEP || state_r == ST_DRAIN, "update outside sweep")
  `KNAP_ASSERT_NOW(a_idle_no_write, !busy, !ram_we, "table written while idle")

endmodule
`default_nettype wire
